// ----- sv/ctd_pkg.sv -----
// Package for the chunked transfer decoder.
// Holds the phase and status codes, the line-flag struct and byte classifiers.
// No dependencies.
package ctd_pkg;

    // Decode phase
    typedef enum logic [1:0] {
        PH_LINE = 2'd0,
        PH_DATA = 2'd1,
        PH_SKIP = 2'd2,
        PH_END  = 2'd3
    } t_phase;

    // End-of-decode status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_BADLINE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Size-line tracking flags
    typedef struct packed {
        logic digit_seen;
        logic digits_stopped;
        logic cr_pending;
    } t_line_flags;

    // One result transaction as queued toward the output
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        t_status    status;
    } t_result;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] TRAILER_LEN = 2'd2;

    // Hex digit check: returns {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ----- sv/ctd_step.sv -----
// Next-state and result logic for one body byte of the chunked decoder.
// Purely combinational; depends on ctd_pkg.
module ctd_step
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_stream,
    input  t_phase               i_phase,
    input  t_line_flags          i_flags,
    input  logic [SIZE_BITS-1:0] i_size_accum,
    input  logic [SIZE_BITS-1:0] i_bytes_left,
    input  logic [1:0]           i_skip_left,
    output t_phase               o_phase,
    output t_line_flags          o_flags,
    output logic [SIZE_BITS-1:0] o_size_accum,
    output logic [SIZE_BITS-1:0] o_bytes_left,
    output logic [1:0]           o_skip_left,
    output logic                 o_has_result,
    output t_result              o_result
);

    logic [4:0]    hex;
    logic          ovf;
    logic          done;
    logic          emit;
    t_status       status;
    t_line_flags   fl;

    assign hex = hex_decode(i_data_byte);

    always_comb begin
        o_phase      = i_phase;
        o_flags      = i_flags;
        o_size_accum = i_size_accum;
        o_bytes_left = i_bytes_left;
        o_skip_left  = i_skip_left;
        done         = 1'b0;
        emit         = 1'b0;
        ovf          = 1'b0;
        status       = ST_OK;
        fl           = i_flags;

        case (i_phase)
            PH_LINE: begin
                if (i_flags.cr_pending && i_data_byte == CH_LF) begin
                    // CR LF closes the size line
                    o_flags.cr_pending = 1'b0;
                    if (!i_flags.digit_seen) begin
                        done   = 1'b1;
                        status = ST_BADLINE;
                    end else if (i_size_accum == '0) begin
                        done   = 1'b1;
                        status = ST_OK;
                    end else begin
                        o_bytes_left = i_size_accum;
                        o_phase      = PH_DATA;
                    end
                end else begin
                    // a lone CR is an ordinary line byte: it only stops digits
                    if (fl.cr_pending) begin
                        fl.cr_pending = 1'b0;
                        if (fl.digit_seen) begin
                            fl.digits_stopped = 1'b1;
                        end
                    end
                    if (i_data_byte == CH_CR) begin
                        fl.cr_pending = 1'b1;
                    end else if (!fl.digits_stopped) begin
                        if (hex[4]) begin
                            if (i_size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                ovf = 1'b1;
                            end else begin
                                o_size_accum  = {i_size_accum[SIZE_BITS-5:0], hex[3:0]};
                                fl.digit_seen = 1'b1;
                            end
                        end else if (!(!fl.digit_seen && is_blank(i_data_byte))) begin
                            fl.digits_stopped = 1'b1;
                        end
                    end
                    o_flags = fl;
                    if (ovf) begin
                        done   = 1'b1;
                        status = ST_OVERFLOW;
                    end
                end
            end
            PH_DATA: begin
                // payload byte passes through
                emit         = 1'b1;
                o_bytes_left = i_bytes_left - SIZE_BITS'(1);
                if (i_bytes_left == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
                    o_phase     = PH_SKIP;
                    o_skip_left = TRAILER_LEN;
                end
            end
            PH_SKIP: begin
                // trailing CR LF skipped unchecked
                o_skip_left = i_skip_left - 2'd1;
                if (i_skip_left == 2'd1) begin
                    o_phase      = PH_LINE;
                    o_size_accum = '0;
                    o_flags      = '0;
                end
            end
            default: begin
                // decode ended: ignore everything
            end
        endcase

        if (i_phase != PH_END) begin
            if (!done && i_end_of_stream) begin
                done   = 1'b1;
                status = ST_TRUNC;
            end
            if (done) begin
                o_phase = PH_END;
            end
        end

        o_has_result        = emit || done;
        o_result.out_byte   = emit ? i_data_byte : 8'd0;
        o_result.byte_valid = emit;
        o_result.done_res   = done;
        o_result.status     = done ? status : ST_OK;
    end

endmodule

// ----- sv/chunked_transfer_decoder.sv -----
// Top level of the HTTP chunked transfer decoder.
// Holds decode state and a two-entry result queue; uses ctd_pkg and ctd_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  input   | in        | i_valid / o_ready  | i_data_byte, i_end_of_stream
//  output  | out       | o_valid / i_ready  | o_out_byte, o_byte_valid, o_done_res, o_status
//
// One body byte is accepted per cycle while o_ready is high; its state update completes in
// the accept cycle and any result is registered into the two-entry result queue.
// o_ready drops only when both queue entries hold untaken results. Reset (i_rst_n
// low, synchronous) returns to the start of a size line and empties the queue.
// After the decode ends, bytes are still accepted and dropped until reset.
module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_done_res,
    output logic [1:0] o_status
);

    // decode state
    t_phase               r_phase, n_phase;
    t_line_flags          r_flags, n_flags;
    logic [SIZE_BITS-1:0] r_size_accum, n_size_accum;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]           r_skip_left, n_skip_left;
    logic                 has_result;
    t_result              result;

    // result queue
    t_result    r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       in_xfer;
    logic       push;
    logic       pop;

    ctd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .i_data_byte    (i_data_byte),
        .i_end_of_stream(i_end_of_stream),
        .i_phase        (r_phase),
        .i_flags        (r_flags),
        .i_size_accum   (r_size_accum),
        .i_bytes_left   (r_bytes_left),
        .i_skip_left    (r_skip_left),
        .o_phase        (n_phase),
        .o_flags        (n_flags),
        .o_size_accum   (n_size_accum),
        .o_bytes_left   (n_bytes_left),
        .o_skip_left    (n_skip_left),
        .o_has_result   (has_result),
        .o_result       (result)
    );

    assign o_ready = (r_count != 2'd2);
    assign in_xfer = i_valid && o_ready;
    assign push    = in_xfer && has_result;
    assign pop     = o_valid && i_ready;

    // state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LINE;
            r_flags      <= '0;
            r_size_accum <= '0;
            r_bytes_left <= '0;
            r_skip_left  <= 2'd0;
        end else if (in_xfer) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_size_accum <= n_size_accum;
            r_bytes_left <= n_bytes_left;
            r_skip_left  <= n_skip_left;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= result;
        end
    end

    assign o_valid      = (r_count != 2'd0);
    assign o_out_byte   = r_queue[r_rd_ptr].out_byte;
    assign o_byte_valid = r_queue[r_rd_ptr].byte_valid;
    assign o_done_res   = r_queue[r_rd_ptr].done_res;
    assign o_status     = r_queue[r_rd_ptr].status;

endmodule
